/* hw/rtl/pdtm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Traffic meter package
// Shared payload types, request classification codes and result kinds.
// ----------------------------------------------------------------------------
package pdtm_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] dest_ip;
        logic [3:0]  header_words;
        logic [15:0] ip_total_length;
    } packet_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  entry_index;
        logic [31:0] entry_address;
        logic [47:0] total_count;
        logic [31:0] current_count;
        logic [31:0] average_count;
        logic        last;
    } result_t;

    localparam logic [2:0] KIND_COUNTED    = 3'd0;
    localparam logic [2:0] KIND_NEW        = 3'd1;
    localparam logic [2:0] KIND_FULL       = 3'd2;
    localparam logic [2:0] KIND_BAD_HEADER = 3'd3;
    localparam logic [2:0] KIND_REPORT     = 3'd4;

    typedef enum logic [1:0] {
        REQ_PACKET = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_BAD    = 2'd2
    } req_kind_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [31:0] dest_ip;
        logic [16:0] length;
    } request_t;

    localparam logic [3:0]  HDR_MIN_WORDS = 4'd5;
    localparam logic [16:0] ETH_OVERHEAD  = 17'd14;
    localparam logic [31:0] SLOT_MAX      = 32'hFFFF_FFFF;
    localparam logic [47:0] TOTAL_MAX     = 48'hFFFF_FFFF_FFFF;

endpackage
`default_nettype wire

/* hw/rtl/pdtm_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pdtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/pdtm_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Small queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module pdtm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/pdtm_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Traffic meter front end
// Accepts input items, classifies them and queues requests for the engine.
// ----------------------------------------------------------------------------
module pdtm_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire pdtm_pkg::packet_t  packet,
    output logic                    full,
    input  wire logic               pop,
    output logic                    req_valid,
    output pdtm_pkg::request_t      req
);
    import pdtm_pkg::*;

    request_t                 req_in;
    logic [$bits(request_t)-1:0] req_vec;
    logic                     empty;

    // The Ethernet overhead is folded in here so the engine only adds.
    always_comb
    begin
        req_in.dest_ip = packet.dest_ip;
        req_in.length  = {1'b0, packet.ip_total_length} + ETH_OVERHEAD;
        priority if (packet.mode)
        begin
            req_in.kind = REQ_TICK;
        end
        else if (packet.header_words < HDR_MIN_WORDS)
        begin
            req_in.kind = REQ_BAD;
        end
        else
        begin
            req_in.kind = REQ_PACKET;
        end
    end

    pdtm_fifo #(
        .WIDTH ($bits(request_t)),
        .DEPTH (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (req_in),
        .full  (full),
        .pop   (pop),
        .rdata (req_vec),
        .empty (empty)
    );

    assign req       = request_t'(req_vec);
    assign req_valid = !empty;
endmodule
`default_nettype wire

/* hw/rtl/pdtm_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Traffic meter engine
// Matches destinations, updates counters and walks the table on ticks.
// ----------------------------------------------------------------------------
module pdtm_back #(
    parameter int ENTRIES = 32,
    parameter int HISTORY = 5
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire pdtm_pkg::request_t  req,
    output logic                     req_pop,
    input  wire logic                res_full,
    output logic                     res_push,
    output pdtm_pkg::result_t        res
);
    import pdtm_pkg::*;

    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int WW    = $clog2(HISTORY + 1);
    localparam int HB    = $clog2(HISTORY);
    localparam int SW    = 32 + HB;
    localparam int DCW   = 2;
    localparam int ROW_W = 32 * HISTORY;
    localparam int DK    = SW + HB;
    localparam int MW    = SW + 1;
    localparam int ML    = 20;
    localparam int PW    = SW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << DK) + 64'(HISTORY - 1)) / 64'(HISTORY));

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MATCH  = 9'b000000010,
        S_LOOKUP = 9'b000000100,
        S_UPDATE = 9'b000001000,
        S_TWAIT  = 9'b000010000,
        S_TROW   = 9'b000100000,
        S_ACC    = 9'b001000000,
        S_DIV    = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [WW-1:0]   warmup_reg, warmup_next;
    request_t        req_reg, req_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            new_reg, new_next;
    logic            warm_reg, warm_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic [PW-1:0]   prod_reg, prod_next;
    logic [HB-1:0]   slot_reg, slot_next;
    logic [DCW-1:0]  div_reg, div_next;
    result_t         res_reg, res_next;
    logic [31:0]     addr_ff [ENTRIES];

    logic            hit;
    logic [IW-1:0]   hit_idx;
    logic            addr_we;
    logic            hist_we, tot_we;
    logic [ROW_W-1:0] hist_wdata, hist_rdata, base_row;
    logic [47:0]     tot_wdata, tot_rdata, base_tot;
    logic [31:0]     addr_rdata;
    logic [32:0]     cur_sum;
    logic [48:0]     tot_sum;
    logic [31:0]     cur_sat;
    logic [47:0]     tot_sat;
    logic [ML-1:0]   mul_coef;
    logic [SW+ML-1:0] mul_out;
    logic            at_last;

    // Destination addresses are unique in the table, so an OR of the
    // matching indices is the match index.
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int e = 0; e < ENTRIES; e++)
        begin
            if ((CW'(e) < count_reg) && (addr_ff[e] == req_reg.dest_ip))
            begin
                hit     = 1'b1;
                hit_idx = hit_idx | IW'(e);
            end
        end
    end

    assign base_row = new_reg ? '0 : hist_rdata;
    assign base_tot = new_reg ? '0 : tot_rdata;
    assign cur_sum  = {1'b0, base_row[31:0]} + 33'(req_reg.length);
    assign tot_sum  = {1'b0, base_tot} + 49'(req_reg.length);
    assign cur_sat  = cur_sum[32] ? SLOT_MAX : cur_sum[31:0];
    assign tot_sat  = tot_sum[48] ? TOTAL_MAX : tot_sum[47:0];
    assign at_last  = (idx_reg == IW'(count_reg - CW'(1)));
    assign mul_coef = (div_reg == '0) ? RECIP[ML-1:0] : ML'(RECIP[MW-1:ML]);
    assign mul_out  = sum_reg * mul_coef;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        warmup_next = warmup_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        new_next    = new_reg;
        warm_next   = warm_reg;
        row_next    = row_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        slot_next   = slot_reg;
        div_next    = div_reg;
        res_next    = res_reg;
        req_pop     = 1'b0;
        res_push    = 1'b0;
        addr_we     = 1'b0;
        hist_we     = 1'b0;
        tot_we      = 1'b0;
        hist_wdata  = {base_row[ROW_W-1:32], cur_sat};
        tot_wdata   = tot_sat;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_pop  = 1'b1;
                    req_next = req;
                    res_next.entry_index   = '0;
                    res_next.entry_address = req.dest_ip;
                    res_next.total_count   = '0;
                    res_next.current_count = '0;
                    res_next.average_count = '0;
                    res_next.last          = 1'b1;
                    unique case (req.kind)
                        REQ_PACKET:
                        begin
                            state_next = S_MATCH;
                        end
                        REQ_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                warm_next = (warmup_reg < WW'(HISTORY));
                                if (warmup_reg < WW'(HISTORY))
                                begin
                                    warmup_next = warmup_reg + WW'(1);
                                end
                                idx_next   = '0;
                                state_next = S_TWAIT;
                            end
                        end
                        default:
                        begin
                            res_next.kind = KIND_BAD_HEADER;
                            state_next    = S_EMIT;
                        end
                    endcase
                end
            end
            S_MATCH:
            begin
                priority if (hit)
                begin
                    idx_next   = hit_idx;
                    new_next   = 1'b0;
                    state_next = S_LOOKUP;
                end
                else if (count_reg < CW'(ENTRIES))
                begin
                    idx_next   = IW'(count_reg);
                    new_next   = 1'b1;
                    addr_we    = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = S_LOOKUP;
                end
                else
                begin
                    res_next.kind = KIND_FULL;
                    state_next    = S_EMIT;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                hist_we = 1'b1;
                tot_we  = 1'b1;
                res_next.kind          = new_reg ? KIND_NEW : KIND_COUNTED;
                res_next.entry_index   = 5'(idx_reg);
                res_next.total_count   = tot_sat;
                res_next.current_count = cur_sat;
                state_next             = S_EMIT;
            end
            S_TWAIT:
            begin
                state_next = S_TROW;
            end
            S_TROW:
            begin
                // Age the row: every slot moves up one and the current slot clears.
                hist_we    = 1'b1;
                hist_wdata = {hist_rdata[ROW_W-33:0], 32'd0};
                row_next   = hist_rdata;
                res_next.kind          = KIND_REPORT;
                res_next.entry_index   = 5'(idx_reg);
                res_next.entry_address = addr_rdata;
                res_next.total_count   = tot_rdata;
                res_next.current_count = hist_rdata[31:0];
                res_next.last          = at_last;
                if (warm_reg)
                begin
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_TWAIT;
                    end
                end
                else
                begin
                    sum_next   = '0;
                    slot_next  = '0;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_next = sum_reg + SW'(row_reg[32 * slot_reg +: 32]);
                if (slot_reg == HB'(HISTORY - 1))
                begin
                    div_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    slot_next = slot_reg + HB'(1);
                end
            end
            S_DIV:
            begin
                // The sum is multiplied by a scaled reciprocal of HISTORY, the low
                // and high halves of the reciprocal on successive cycles.
                unique case (div_reg)
                    2'd0:
                    begin
                        prod_next = PW'(mul_out);
                        div_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        prod_next = prod_reg + (PW'(mul_out) << ML);
                        div_next  = 2'd2;
                    end
                    default:
                    begin
                        res_next.average_count = prod_reg[DK +: 32];
                        state_next             = S_EMIT;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if ((res_reg.kind == KIND_REPORT) && !res_reg.last)
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_TWAIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            warmup_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            warmup_reg <= warmup_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        idx_reg  <= idx_next;
        new_reg  <= new_next;
        warm_reg <= warm_next;
        row_reg  <= row_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        slot_reg <= slot_next;
        div_reg  <= div_next;
        res_reg  <= res_next;
        if (addr_we)
        begin
            addr_ff[IW'(count_reg)] <= req_reg.dest_ip;
        end
    end

    assign res = res_reg;

    pdtm_ram #(
        .WIDTH (32),
        .DEPTH (ENTRIES)
    ) u_addr_ram (
        .clk   (clk),
        .we    (addr_we),
        .waddr (IW'(count_reg)),
        .wdata (req_reg.dest_ip),
        .raddr (idx_reg),
        .rdata (addr_rdata)
    );

    pdtm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (idx_reg),
        .wdata (hist_wdata),
        .raddr (idx_reg),
        .rdata (hist_rdata)
    );

    pdtm_ram #(
        .WIDTH (48),
        .DEPTH (ENTRIES)
    ) u_total_ram (
        .clk   (clk),
        .we    (tot_we),
        .waddr (idx_reg),
        .wdata (tot_wdata),
        .raddr (idx_reg),
        .rdata (tot_rdata)
    );
endmodule
`default_nettype wire

/* hw/rtl/per_destination_traffic_meter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Per-destination traffic meter
// Counts bytes per destination address and reports per-tick averages.
// ----------------------------------------------------------------------------
// A two-entry request queue takes items while the engine works, and a
// two-entry result queue holds finished results. The engine handles one
// request at a time: a packet goes through match against the address
// registers, counter memory read, saturating update and result. A warm-up
// tick reads and ages the history row of each table entry in turn. A
// reporting tick, for each entry, reads and ages the row, forms the
// slot-by-slot sum, does a reciprocal multiply for the divide by HISTORY,
// and emits the result. A full result queue stalls the engine.
module per_destination_traffic_meter #(
    parameter int ENTRIES = 32,
    parameter int HISTORY = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire pdtm_pkg::packet_t  packet,
    output logic                    full,
    input  wire logic               pop,
    output logic                    empty,
    output pdtm_pkg::result_t       result
);
    import pdtm_pkg::*;

    request_t req;
    logic     req_valid, req_pop;
    result_t  res;
    logic     res_push, res_full;
    logic [$bits(result_t)-1:0] res_vec;

    pdtm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .packet    (packet),
        .full      (full),
        .pop       (req_pop),
        .req_valid (req_valid),
        .req       (req)
    );

    pdtm_back #(
        .ENTRIES (ENTRIES),
        .HISTORY (HISTORY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_pop   (req_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    pdtm_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_vec),
        .empty (empty)
    );

    assign result = result_t'(res_vec);

`ifndef ASSERT_OFF
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req_pop |-> req_valid)
        else $error("engine took a request from an empty queue");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res.kind != KIND_REPORT)) |-> res.last)
        else $error("packet result without last flag");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> (empty && !full))
        else $error("queues not empty in reset");
`endif
endmodule
`default_nettype wire

/* bench/per_destination_traffic_meter_tb.sv */
// ----------------------------------------------------------------------------
// Per-destination traffic meter testbench
// Drives packet and tick requests through the input queue, predicts every
// result with a behavioral model of the meter, and checks each popped result
// field by field. Both sides idle at random, with short and long gaps.
// ----------------------------------------------------------------------------
module per_destination_traffic_meter_tb;

    import pdtm_pkg::*;

    localparam int ENTRIES   = 32;
    localparam int HISTORY   = 5;
    localparam int IDLE_LIMIT = 20000;

    // Predicts meter results and holds them until the block produces them.
    class meter_scoreboard;
        int unsigned used_entries;
        logic [31:0] addresses [ENTRIES];
        logic [31:0] slots [ENTRIES][HISTORY];
        logic [47:0] totals [ENTRIES];
        int unsigned warmup;
        result_t     pending [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned report_count;
        int unsigned full_count;

        function void clear();
            used_entries = 0;
            warmup = 0;
            pending.delete();
            mismatches = 0;
            checked = 0;
            report_count = 0;
            full_count = 0;
        endfunction

        function void note_request(packet_t p);
            result_t r;
            int e;
            logic [32:0] slot_sum;
            logic [48:0] total_sum;
            logic [35:0] hist_sum;
            logic [16:0] bytes;
            r = '0;
            r.last = 1'b1;
            if (p.mode == 1'b0)
            begin
                r.entry_address = p.dest_ip;
                if (p.header_words < HDR_MIN_WORDS)
                begin
                    r.kind = KIND_BAD_HEADER;
                    pending.push_back(r);
                    return;
                end
                e = -1;
                for (int i = 0; i < used_entries; i++)
                    if (e < 0 && addresses[i] == p.dest_ip)
                        e = i;
                if (e >= 0)
                begin
                    r.kind = KIND_COUNTED;
                end
                else if (used_entries < ENTRIES)
                begin
                    e = used_entries;
                    used_entries++;
                    addresses[e] = p.dest_ip;
                    for (int s = 0; s < HISTORY; s++)
                        slots[e][s] = '0;
                    totals[e] = '0;
                    r.kind = KIND_NEW;
                end
                else
                begin
                    r.kind = KIND_FULL;
                    full_count++;
                    pending.push_back(r);
                    return;
                end
                bytes = {1'b0, p.ip_total_length} + ETH_OVERHEAD;
                slot_sum = {1'b0, slots[e][0]} + bytes;
                slots[e][0] = slot_sum[32] ? SLOT_MAX : slot_sum[31:0];
                total_sum = {1'b0, totals[e]} + bytes;
                totals[e] = total_sum[48] ? TOTAL_MAX : total_sum[47:0];
                r.entry_index = e[4:0];
                r.total_count = totals[e];
                r.current_count = slots[e][0];
                pending.push_back(r);
                return;
            end
            if (used_entries == 0)
                return;
            for (int i = 0; i < used_entries; i++)
            begin
                if (warmup >= HISTORY)
                begin
                    hist_sum = '0;
                    for (int s = 0; s < HISTORY; s++)
                        hist_sum += slots[i][s];
                    r.kind = KIND_REPORT;
                    r.entry_index = i[4:0];
                    r.entry_address = addresses[i];
                    r.total_count = totals[i];
                    r.current_count = slots[i][0];
                    r.average_count = 32'(hist_sum / HISTORY);
                    r.last = (i + 1 == used_entries);
                    pending.push_back(r);
                    report_count++;
                end
                for (int s = HISTORY - 1; s > 0; s--)
                    slots[i][s] = slots[i][s - 1];
                slots[i][0] = '0;
            end
            if (warmup < HISTORY)
                warmup++;
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.entry_index !== want.entry_index
                    || got.entry_address !== want.entry_address
                    || got.total_count !== want.total_count
                    || got.current_count !== want.current_count
                    || got.average_count !== want.average_count
                    || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                             want, got);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    push;
    packet_t packet;
    logic    full;
    logic    pop;
    logic    empty;
    result_t result;

    meter_scoreboard meter;
    int unsigned     idle_cycles;
    int unsigned     sent_count;
    logic [31:0]     known_ips [$];

    per_destination_traffic_meter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .packet (packet),
        .full   (full),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Mostly short gaps, occasionally a long one.
    function automatic int unsigned gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with push still high, so back-to-back requests need no extra edge.
    task automatic send_request(packet_t p);
        int unsigned gap;
        gap = gap_length();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        packet <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
        meter.note_request(p);
        sent_count++;
        @(negedge clk);
    endtask

    function automatic packet_t make_packet(logic [31:0] ip, logic [3:0] hw,
                                            logic [15:0] len);
        packet_t p;
        p.mode = 1'b0;
        p.dest_ip = ip;
        p.header_words = hw;
        p.ip_total_length = len;
        return p;
    endfunction

    function automatic packet_t make_tick();
        packet_t p;
        p = '0;
        p.mode = 1'b1;
        p.dest_ip = $urandom;
        p.header_words = 4'($urandom_range(0, 15));
        p.ip_total_length = 16'($urandom);
        return p;
    endfunction

    function automatic packet_t random_packet();
        logic [31:0] ip;
        logic [3:0]  hw;
        logic [15:0] len;
        if (known_ips.size() > 0 && $urandom_range(0, 99) < 70)
            ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
        else
            ip = $urandom;
        hw = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 4))
                                          : 4'($urandom_range(5, 15));
        len = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
        return make_packet(ip, hw, len);
    endfunction

    // Result side: random back-pressure via pop.
    initial
    begin
        int unsigned gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = gap_length();
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            meter.check_result(result);
        end
    end

    // Watchdog on cycles where nothing is accepted.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned settle;
        meter = new();
        meter.clear();
        rst_n = 1'b0;
        push = 1'b0;
        packet = '0;
        sent_count = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty-table tick, header edge, extremes, warm-up ticks.
        send_request(make_tick());
        send_request(make_packet(32'h0000_0000, 4'd4, 16'hFFFF));
        send_request(make_packet(32'hFFFF_FFFF, 4'd0, 16'h0000));
        send_request(make_packet(32'h0000_0000, 4'd5, 16'h0000));
        send_request(make_packet(32'hFFFF_FFFF, 4'd15, 16'hFFFF));
        send_request(make_packet(32'hFFFF_FFFF, 4'd5, 16'hFFFF));
        send_request(make_packet(32'hA5A5_5A5A, 4'd6, 16'h1234));
        for (int i = 0; i < 6; i++)
            send_request(make_tick());
        send_request(make_packet(32'h0000_0000, 4'd5, 16'd100));
        send_request(make_tick());
        known_ips.push_back(32'h0000_0000);
        known_ips.push_back(32'hFFFF_FFFF);
        known_ips.push_back(32'hA5A5_5A5A);

        // Random part; a stretch in the middle fills the table to overflow.
        for (int n = 0; n < 300; n++)
        begin
            packet_t p;
            if (n >= 120 && n < 160)
                p = make_packet($urandom, 4'($urandom_range(5, 15)), 16'($urandom));
            else if ($urandom_range(0, 99) < 8)
                p = make_tick();
            else
                p = random_packet();
            if (p.mode == 1'b0 && p.header_words >= HDR_MIN_WORDS
                    && known_ips.size() < 40)
                known_ips.push_back(p.dest_ip);
            send_request(p);
        end
        send_request(make_tick());
        push <= 1'b0;

        while (meter.pending.size() != 0)
            @(posedge clk);
        settle = 0;
        while (settle < 3000)
        begin
            @(posedge clk);
            settle++;
        end

        $display("Sent %0d requests and checked %0d results, %0d of them reports.",
                 sent_count, meter.checked, meter.report_count);
        $display("Table-full drops seen: %0d; mismatches: %0d.",
                 meter.full_count, meter.mismatches);
        if (meter.mismatches == 0 && meter.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* per_destination_traffic_meter.f */
hw/rtl/pdtm_pkg.sv
hw/rtl/pdtm_ram.sv
hw/rtl/pdtm_fifo.sv
hw/rtl/pdtm_front.sv
hw/rtl/pdtm_back.sv
hw/rtl/per_destination_traffic_meter.sv
bench/per_destination_traffic_meter_tb.sv
